[hw/rtl/rms_pkg.sv]
// Shared types and constants of the rolling median smoother.
package rms_pkg;

  localparam int SAMPLE_BITS       = 24;
  localparam int HALF_BITS         = 3;
  localparam int REP_BITS          = 4;
  localparam int MAX_HALF_DEFAULT  = 7;
  localparam int QUEUE_DEPTH_DEFAULT = 4;
  localparam logic [HALF_BITS-1:0] HALF_RESET = 3'd6;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t sample;
    logic    last_sample;
  } item_t;

  typedef struct packed {
    sample_t filtered;
    logic    run_end;
    logic    sweep_end;
    logic    short_sweep;
  } result_t;

  // One queued job: a median to be repeated or a single raw point.
  typedef struct packed {
    sample_t               value;
    logic [HALF_BITS-1:0]  half;
    logic                  first;
    logic                  run_end;
    logic                  sweep_end;
    logic                  short_sweep;
  } entry_t;

endpackage

[hw/rtl/rms_fifo.sv]
// Small job queue between the front and back parts.
module rms_fifo #(
  parameter int DEPTH = rms_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rms_pkg::entry_t wr_entry,
  output logic            full,
  input  logic            pop,
  output rms_pkg::entry_t rd_entry,
  output logic            rd_valid
);
  import rms_pkg::*;

  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  entry_t              slots [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign full     = (count == CNT_BITS'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

endmodule

[hw/rtl/rms_front.sv]
// Front part: window line, sweep bookkeeping and the pipelined median unit.
module rms_front #(
  parameter int MAX_HALF = rms_pkg::MAX_HALF_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  rms_pkg::item_t                 item,
  input  logic                           cfg_valid,
  input  logic [rms_pkg::HALF_BITS-1:0]  cfg_half_width,
  output logic                           push,
  output rms_pkg::entry_t                entry,
  input  logic                           fifo_full
);
  import rms_pkg::*;

  localparam int LINE     = 2 * MAX_HALF + 1;
  localparam int IDX_BITS = $clog2(LINE);
  localparam int CNT_BITS = $clog2(LINE + 1);

  logic [HALF_BITS-1:0] half_width;
  logic [CNT_BITS-1:0]  fill_count;
  logic [CNT_BITS-1:0]  dump_cnt;
  sample_t              window_line [LINE];

  logic                 a_valid;
  logic                 a_median;
  entry_t               a_info;
  logic                 b_valid;
  logic                 b_median;
  entry_t               b_info;
  logic [LINE-1:0]      b_prec [LINE];
  sample_t              b_win [LINE];
  logic                 c_valid;
  entry_t               c_info;
  entry_t               c_info_next;

  logic [HALF_BITS-1:0] h;
  logic [CNT_BITS-1:0]  w;
  logic [CNT_BITS-1:0]  fc_new;
  logic                 full_now;
  logic                 first;
  logic                 accept;
  logic                 ready_a;
  logic                 ready_b;
  logic                 ready_c;
  logic [CNT_BITS-1:0]  w_a;
  logic [CNT_BITS-1:0]  w_b;
  logic [LINE-1:0]      prec [LINE];
  logic [CNT_BITS-1:0]  rank [LINE];
  sample_t              median;

  always_comb begin
    h = half_width;
    if (h == '0) begin
      h = HALF_BITS'(1);
    end
    if (int'(h) > MAX_HALF) begin
      h = HALF_BITS'(MAX_HALF);
    end
  end

  assign w        = CNT_BITS'(2 * int'(h) + 1);
  assign fc_new   = (fill_count < w) ? fill_count + 1'b1 : fill_count;
  assign full_now = (fc_new == w);
  assign first    = (fill_count + 1'b1 == w);

  assign ready_c    = !c_valid || !fifo_full;
  assign ready_b    = !b_valid || ready_c;
  assign ready_a    = !a_valid || ready_b;
  assign item_ready = ready_a && (dump_cnt == '0);
  assign accept     = item_valid && item_ready;

  assign push  = c_valid && !fifo_full;
  assign entry = c_info;

  // Pairwise order of the window: j precedes i when smaller, ties broken by
  // position, so the ranks of the valid entries form a permutation.
  assign w_a = CNT_BITS'(2 * int'(a_info.half) + 1);

  always_comb begin
    for (int i = 0; i < LINE; i++) begin
      for (int j = 0; j < LINE; j++) begin
        if (i == j || CNT_BITS'(j) >= w_a) begin
          prec[i][j] = 1'b0;
        end else if (j < i) begin
          prec[i][j] = (window_line[j] <= window_line[i]);
        end else begin
          prec[i][j] = (window_line[j] < window_line[i]);
        end
      end
    end
  end

  assign w_b = CNT_BITS'(2 * int'(b_info.half) + 1);

  always_comb begin
    median = '0;
    for (int i = 0; i < LINE; i++) begin
      rank[i] = '0;
      for (int j = 0; j < LINE; j++) begin
        rank[i] = rank[i] + CNT_BITS'(b_prec[i][j]);
      end
      if (CNT_BITS'(i) < w_b && rank[i] == CNT_BITS'(b_info.half)) begin
        median = median | b_win[i];
      end
    end
  end

  always_comb begin
    c_info_next = b_info;
    if (b_median) begin
      c_info_next.value = median;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_width <= HALF_RESET;
      fill_count <= '0;
      dump_cnt   <= '0;
      a_valid    <= 1'b0;
      b_valid    <= 1'b0;
      c_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        half_width <= cfg_half_width;
        fill_count <= '0;
      end
      if (accept) begin
        if (!full_now) begin
          if (item.last_sample) begin
            dump_cnt   <= fc_new;
            fill_count <= '0;
          end else begin
            fill_count <= fc_new;
          end
        end else begin
          fill_count <= item.last_sample ? '0 : fc_new;
        end
      end
      if (ready_a) begin
        a_valid <= (accept && full_now) || (dump_cnt != '0);
        if (dump_cnt != '0) begin
          dump_cnt <= dump_cnt - 1'b1;
        end
      end
      if (ready_b) begin
        b_valid <= a_valid;
      end
      if (ready_c) begin
        c_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      window_line[0] <= item.sample;
      for (int i = 1; i < LINE; i++) begin
        window_line[i] <= window_line[i-1];
      end
    end
    if (ready_a) begin
      a_median  <= (dump_cnt == '0);
      a_info.half <= h;
      if (dump_cnt != '0) begin
        // Short sweep: stored points leave oldest first.
        a_info.value       <= window_line[IDX_BITS'(dump_cnt - 1'b1)];
        a_info.first       <= 1'b0;
        a_info.run_end     <= (dump_cnt == CNT_BITS'(1));
        a_info.sweep_end   <= (dump_cnt == CNT_BITS'(1));
        a_info.short_sweep <= 1'b1;
      end else begin
        a_info.value       <= '0;
        a_info.first       <= first;
        a_info.run_end     <= 1'b1;
        a_info.sweep_end   <= item.last_sample;
        a_info.short_sweep <= 1'b0;
      end
    end
    if (ready_b) begin
      b_median <= a_median;
      b_info   <= a_info;
      b_prec   <= prec;
      b_win    <= window_line;
    end
    if (ready_c) begin
      c_info <= c_info_next;
    end
  end

endmodule

[hw/rtl/rms_back.sv]
// Back part: expands queued jobs into result words behind an output register.
module rms_back (
  input  logic             clk,
  input  logic             rst,
  input  rms_pkg::entry_t  head,
  input  logic             head_valid,
  output logic             pop,
  output logic             result_valid,
  input  logic             result_ready,
  output rms_pkg::result_t result
);
  import rms_pkg::*;

  entry_t              cur;
  logic                cur_valid;
  logic [REP_BITS-1:0] remaining;

  logic                final_rep;
  logic                out_take;
  logic [REP_BITS-1:0] base_reps;
  logic [REP_BITS-1:0] tail_reps;
  logic [REP_BITS-1:0] head_reps;

  // The first median also covers the leading border; a sweep's last median
  // also covers the trailing border.
  assign base_reps = head.first ? REP_BITS'(head.half) + 1'b1 : REP_BITS'(1);
  assign tail_reps = (head.sweep_end && !head.short_sweep) ? REP_BITS'(head.half) : '0;
  assign head_reps = base_reps + tail_reps;

  assign final_rep = (remaining == REP_BITS'(1));
  assign out_take  = cur_valid && result_ready;
  assign pop       = head_valid && (!cur_valid || (out_take && final_rep));

  assign result_valid       = cur_valid;
  assign result.filtered    = cur.value;
  assign result.run_end     = final_rep && cur.run_end;
  assign result.sweep_end   = final_rep && cur.sweep_end;
  assign result.short_sweep = cur.short_sweep;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      remaining <= '0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
        remaining <= head_reps;
      end else if (out_take) begin
        if (final_rep) begin
          cur_valid <= 1'b0;
        end else begin
          remaining <= remaining - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

endmodule

[hw/rtl/rolling_median_smoother.sv]
// A median job passes front stages a, b and c, the job queue and the back part's output
// register; raw points of a short sweep are read out by the dump counter first, and the
// input is held off until all are out. Throughput: one sample word per cycle while the queue
// takes jobs; border runs leave the back part at one word a cycle while result_ready is high.
// Reset (synchronous, active high) empties all stages and the queue, sets half_width to 6
// and starts a new sweep; the window line itself is not cleared.
module rolling_median_smoother #(
  parameter int MAX_HALF    = rms_pkg::MAX_HALF_DEFAULT,
  parameter int QUEUE_DEPTH = rms_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  rms_pkg::item_t                item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rms_pkg::HALF_BITS-1:0] cfg_half_width,
  output logic                          result_valid,
  input  logic                          result_ready,
  output rms_pkg::result_t              result
);
  import rms_pkg::*;

  // Jobs travel from the front part to the back part through the queue.
  logic   push;
  entry_t push_entry;
  logic   fifo_full;
  logic   pop;
  entry_t head;
  logic   head_valid;

  // The configuration word is taken at once and restarts the sweep in progress; it is only written while the
  // block is idle as a rule for the user, which the block itself does not enforce.
  assign cfg_ready = 1'b1;

  // The front part shifts each sample word into the window line, counts the
  // sweep and, once a window is full, ranks its entries pairwise and picks
  // the one in the middle. At the end of a short sweep it replays the stored
  // points as raw jobs, one per cycle unless the queue is full, and holds off new sample words.
  rms_front #(
    .MAX_HALF (MAX_HALF)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .item           (item),
    .cfg_valid      (cfg_valid),
    .cfg_half_width (cfg_half_width),
    .push           (push),
    .entry          (push_entry),
    .fifo_full      (fifo_full)
  );

  rms_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (push_entry),
    .full     (fifo_full),
    .pop      (pop),
    .rd_entry (head),
    .rd_valid (head_valid)
  );

  // The back part turns each job into one or more result words, so the
  // border repeats never stall the sample side while the queue has room.
  rms_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (head_valid),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

[hw/rtl/rms_checker.sv]
// Port-level checks of the rolling median smoother, bound to the top level.
module rms_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_ready,
  input logic             result_valid,
  input logic             result_ready,
  input rms_pkg::result_t result
);
  import rms_pkg::*;

  // An offered sample word stays offered until it is taken.
  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_ready |=> item_valid)
    else $error("sample word withdrawn before it was taken");

  // A stalled result word holds its value.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  // The end of a sweep is always the end of the run for that sample.
  a_sweep_end_run_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.sweep_end |-> result.run_end)
    else $error("sweep_end without run_end");

  // Raw points of a short sweep are never interleaved with medians.
  a_short_run: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && result.short_sweep && !result.run_end
    |=> !result_valid || result.short_sweep)
    else $error("short sweep broken by a median");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result word valid after reset");

endmodule

bind rolling_median_smoother rms_checker u_rms_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

[test/rolling_median_smoother_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the rolling median smoother: directed sweeps, then random phases.
module rolling_median_smoother_tb;
  import rms_pkg::*;

  // The predictor mirrors the block's default window line.
  localparam int MAX_HALF = MAX_HALF_DEFAULT;
  localparam int LINE_DEPTH = 2 * MAX_HALF + 1;

  // Extremes of a Q16.8 sample.
  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  // Idle wait that lets the pipeline drain before a register write or the end of the run; it
  // covers the path from a taken item to its first result word, also for the raw points of
  // a short sweep.
  localparam int SETTLE_CYCLES = 8;
  // Cycles without any accepted word before the run is declared hung. The slowest correct
  // stretch is the long receiver hold below plus a few idle bursts, so this is generous.
  localparam int WATCHDOG_LIMIT = 1000;
  // The receiver holds off once for this long after this many result words.
  localparam int LONG_HOLD = 64;
  localparam int HOLD_AFTER = 150;
  // Random items per half-width phase, at least; the sweep that crosses this count is still closed.
  localparam int PHASE_ITEMS = 36;
  localparam int NUM_PHASES = 8;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // One step of the directed part. Rows marked typed carry their expected result words:
  // word_count words of word_value, closed by run_end (and sweep_end on a last sample).
  typedef struct packed {
    row_kind_t                kind;
    logic [HALF_BITS-1:0]     half;
    sample_t                  sample;
    logic                     last;
    logic                     typed;
    logic [3:0]               word_count;
    sample_t                  word_value;
    logic                     word_short;
  } drill_row_t;

  localparam int DRILL_ROWS = 26;

  drill_row_t drill_table [0:DRILL_ROWS-1] = '{
    // A one-point sweep right after reset is shorter than any window: passed through raw.
    '{ROW_ITEM, 3'd0, 24'sh012345, 1'b1, 1'b1, 4'd1, 24'sh012345, 1'b1},
    // Window of 3, filled with the positive extreme, then with the negative one. The
    // single median of each sweep also covers one border point at each end.
    '{ROW_CFG,  3'd1, '0,          1'b0, 1'b0, 4'd0, '0,          1'b0},
    '{ROW_ITEM, 3'd0, SAMPLE_MAX,  1'b0, 1'b1, 4'd0, '0,          1'b0},
    '{ROW_ITEM, 3'd0, SAMPLE_MAX,  1'b0, 1'b1, 4'd0, '0,          1'b0},
    '{ROW_ITEM, 3'd0, SAMPLE_MAX,  1'b1, 1'b1, 4'd3, SAMPLE_MAX,  1'b0},
    '{ROW_ITEM, 3'd0, SAMPLE_MIN,  1'b0, 1'b1, 4'd0, '0,          1'b0},
    '{ROW_ITEM, 3'd0, SAMPLE_MIN,  1'b0, 1'b1, 4'd0, '0,          1'b0},
    '{ROW_ITEM, 3'd0, SAMPLE_MIN,  1'b1, 1'b1, 4'd3, SAMPLE_MIN,  1'b0},
    // Mixed signs and extremes in one sweep with a window of 3.
    '{ROW_ITEM, 3'd0, 24'sd100,    1'b0, 1'b0, 4'd0, '0,          1'b0},
    '{ROW_ITEM, 3'd0, -24'sd200,   1'b0, 1'b0, 4'd0, '0,          1'b0},
    '{ROW_ITEM, 3'd0, 24'sd50,     1'b0, 1'b0, 4'd0, '0,          1'b0},
    '{ROW_ITEM, 3'd0, -24'sd1,     1'b0, 1'b0, 4'd0, '0,          1'b0},
    '{ROW_ITEM, 3'd0, SAMPLE_MAX,  1'b0, 1'b0, 4'd0, '0,          1'b0},
    '{ROW_ITEM, 3'd0, SAMPLE_MIN,  1'b1, 1'b0, 4'd0, '0,          1'b0},
    // A half width of zero behaves as one; a two-point sweep is short and comes out raw.
    '{ROW_CFG,  3'd0, '0,          1'b0, 1'b0, 4'd0, '0,          1'b0},
    '{ROW_ITEM, 3'd0, 24'sd11,     1'b0, 1'b0, 4'd0, '0,          1'b0},
    '{ROW_ITEM, 3'd0, -24'sd11,    1'b1, 1'b0, 4'd0, '0,          1'b0},
    // A register write drops the sweep in progress, even when it rewrites the same value.
    '{ROW_CFG,  3'd2, '0,          1'b0, 1'b0, 4'd0, '0,          1'b0},
    '{ROW_ITEM, 3'd0, 24'sd3,      1'b0, 1'b1, 4'd0, '0,          1'b0},
    '{ROW_ITEM, 3'd0, 24'sd4,      1'b0, 1'b1, 4'd0, '0,          1'b0},
    '{ROW_ITEM, 3'd0, 24'sd5,      1'b0, 1'b1, 4'd0, '0,          1'b0},
    '{ROW_CFG,  3'd2, '0,          1'b0, 1'b0, 4'd0, '0,          1'b0},
    '{ROW_ITEM, 3'd0, -24'sd7,     1'b1, 1'b1, 4'd1, -24'sd7,     1'b1},
    // Widest window, short sweep.
    '{ROW_CFG,  3'd7, '0,          1'b0, 1'b0, 4'd0, '0,          1'b0},
    '{ROW_ITEM, 3'd0, 24'sd1,      1'b0, 1'b0, 4'd0, '0,          1'b0},
    '{ROW_ITEM, 3'd0, 24'sd2,      1'b1, 1'b0, 4'd0, '0,          1'b0}
  };

  logic [HALF_BITS-1:0] phase_halves [0:NUM_PHASES-1] =
    '{3'd3, 3'd7, 3'd0, 3'd1, 3'd5, 3'd2, 3'd4, 3'd6};

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 item_valid = 1'b0;
  logic                 item_ready;
  item_t                item = '0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [HALF_BITS-1:0] cfg_half_width = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  result_t              result;

  // Predictor state: newest sample at index 0, points of the current sweep, register.
  sample_t              recent_points [0:LINE_DEPTH-1] = '{default: '0};
  int unsigned          sweep_fill = 0;
  logic [HALF_BITS-1:0] half_setting = HALF_RESET;

  result_t step_words[$];       // words caused by the item just taken
  result_t pending_results[$];  // words still owed by the block, oldest first

  int  mismatches = 0;
  int  words_seen = 0;
  int  stall_left = 0;
  int  quiet_cycles = 0;
  bit  hold_done = 1'b0;
  bit  calm = 1'b0;             // no idling on either side in the closing phase

  rolling_median_smoother i_dut (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_half_width(cfg_half_width),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result        (result)
  );

  always #5 clk = ~clk;

  // Advances the predictor by one sample and leaves the words it causes in step_words.
  task automatic median_step(input item_t w);
    int unsigned h;
    int unsigned span;
    int unsigned reps;
    bit          opening;
    sample_t     ordered [0:LINE_DEPTH-1];
    sample_t     pick;
    sample_t     med;
    result_t     word;
    int          j;
    step_words.delete();
    h = (half_setting == 0) ? 1 : ((half_setting > MAX_HALF) ? MAX_HALF : half_setting);
    span = 2 * h + 1;
    for (int i = LINE_DEPTH - 1; i > 0; i--) recent_points[i] = recent_points[i - 1];
    recent_points[0] = w.sample;
    if (sweep_fill > span) sweep_fill = span;
    opening = (sweep_fill + 1 == span);
    if (sweep_fill < span) sweep_fill++;
    if (sweep_fill < span) begin
      // Window never filled: a last sample flushes the stored points raw, oldest first.
      if (w.last_sample) begin
        for (int i = sweep_fill; i > 0; i--) begin
          word.filtered = recent_points[i - 1];
          word.run_end = (i == 1);
          word.sweep_end = (i == 1);
          word.short_sweep = 1'b1;
          step_words.push_back(word);
        end
        sweep_fill = 0;
      end
      return;
    end
    // Median of the full window by insertion sort.
    for (int i = 0; i < span; i++) begin
      pick = recent_points[i];
      j = i;
      while (j > 0 && ordered[j - 1] > pick) begin
        ordered[j] = ordered[j - 1];
        j--;
      end
      ordered[j] = pick;
    end
    med = ordered[h];
    // The opening median also covers the leading border, the closing one the trailing.
    reps = opening ? h + 1 : 1;
    if (w.last_sample) reps += h;
    for (int k = 0; k < reps; k++) begin
      word.filtered = med;
      word.run_end = (k == reps - 1);
      word.sweep_end = (k == reps - 1) && w.last_sample;
      word.short_sweep = 1'b0;
      step_words.push_back(word);
    end
    if (w.last_sample) sweep_fill = 0;
  endtask

  // Offers one sample word, possibly after an idle burst, and waits until it is taken.
  task automatic send_word(input item_t w, input bit keep_prediction);
    if (!calm && $urandom_range(0, 4) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    item <= w;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    median_step(w);
    if (keep_prediction) foreach (step_words[i]) pending_results.push_back(step_words[i]);
  endtask

  // Writes the half width once the block has delivered everything and gone quiet.
  task automatic write_half(input logic [HALF_BITS-1:0] setting);
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // Samples that cause no word may still be in the pipeline.
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_half_width <= setting;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    half_setting = setting;
    sweep_fill = 0;
  endtask

  // Stimulus: reset, the directed table, then one random phase per half width.
  initial begin
    drill_row_t  row;
    item_t       w;
    result_t     word;
    int unsigned h;
    int unsigned span;
    int unsigned len;
    int unsigned sent;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DRILL_ROWS; r++) begin
      row = drill_table[r];
      if (row.kind == ROW_CFG) begin
        write_half(row.half);
      end else begin
        w.sample = row.sample;
        w.last_sample = row.last;
        send_word(w, !row.typed);
        for (int k = 0; k < row.word_count; k++) begin
          word.filtered = row.word_value;
          word.run_end = (k == row.word_count - 1);
          word.sweep_end = (k == row.word_count - 1) && row.last;
          word.short_sweep = row.word_short;
          pending_results.push_back(word);
        end
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == NUM_PHASES - 1) calm = 1'b1;
      write_half(phase_halves[p]);
      h = (phase_halves[p] == 0) ? 1 : phase_halves[p];
      span = 2 * h + 1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // Mostly full sweeps with border runs at both ends; now and then a short one.
        if ($urandom_range(0, 4) == 0) len = $urandom_range(1, span - 1);
        else len = $urandom_range(span, span + 12);
        for (int k = 0; k < len; k++) begin
          case ($urandom_range(0, 7))
            0: w.sample = SAMPLE_MAX;
            1: w.sample = SAMPLE_MIN;
            // Narrow range, so the window holds many equal values.
            2, 3: w.sample = sample_t'(int'($urandom_range(0, 8)) - 4);
            default: w.sample = sample_t'($urandom);
          endcase
          w.last_sample = (k == len - 1);
          send_word(w, 1'b1);
        end
        sent += len;
      end
      // Sometimes leave a sweep open; the next register write must throw it away.
      if ($urandom_range(0, 1) == 1) begin
        len = $urandom_range(1, span + 3);
        for (int k = 0; k < len; k++) begin
          w.sample = sample_t'($urandom);
          w.last_sample = 1'b0;
          send_word(w, 1'b1);
        end
      end
    end

    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Receiver: random stall bursts, and one long hold-off while the
  // sender keeps offering, so the job queue fills and item_ready has to drop.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      result_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!hold_done && words_seen >= HOLD_AFTER) begin
      result_ready <= 1'b0;
      stall_left <= LONG_HOLD - 1;
      hold_done <= 1'b1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      result_ready <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      result_ready <= 1'b1;
    end
  end

  // Each result word taken is checked against the oldest expectation, field by field.
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && result_ready) begin
      words_seen <= words_seen + 1;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: filtered %0d run_end %0b sweep_end %0b short %0b",
                   result.filtered, result.run_end, result.sweep_end, result.short_sweep);
      end else begin
        want = pending_results.pop_front();
        if (result.filtered !== want.filtered || result.run_end !== want.run_end ||
            result.sweep_end !== want.sweep_end || result.short_sweep !== want.short_sweep)
        begin
          mismatches++;
          if (mismatches <= 10)
            $display("result word %0d: expected %0d/%0b/%0b/%0b got %0d/%0b/%0b/%0b",
                     words_seen, want.filtered, want.run_end, want.sweep_end,
                     want.short_sweep, result.filtered, result.run_end, result.sweep_end,
                     result.short_sweep);
        end
      end
    end
  end

  // Watchdog: ends the run if no word moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

[rolling_median_smoother.f]
hw/rtl/rms_pkg.sv
hw/rtl/rms_fifo.sv
hw/rtl/rms_front.sv
hw/rtl/rms_back.sv
hw/rtl/rolling_median_smoother.sv
hw/rtl/rms_checker.sv
test/rolling_median_smoother_tb.sv
